// File: sv/scfe_pkg.sv
// Shared types, codes and constants of the stepper command frame encoder.
package scfe_pkg;

    localparam int FRAME_MAX = 12;

    localparam logic [2:0] KIND_ENABLE    = 3'd0;
    localparam logic [2:0] KIND_VELOCITY  = 3'd1;
    localparam logic [2:0] KIND_POSITION  = 3'd2;
    localparam logic [2:0] KIND_STOP      = 3'd3;
    localparam logic [2:0] KIND_CALIBRATE = 3'd4;

    localparam logic [1:0] MODE_CONST = 2'd0;
    localparam logic [1:0] MODE_XOR   = 2'd1;
    localparam logic [1:0] MODE_CRC   = 2'd2;

    localparam logic [7:0] CHECK_CONST  = 8'h6B;
    localparam logic [7:0] CRC_POLY     = 8'h07;
    localparam logic [7:0] OP_ENABLE    = 8'hF3;
    localparam logic [7:0] SUB_ENABLE   = 8'hAB;
    localparam logic [7:0] OP_VELOCITY  = 8'hF6;
    localparam logic [7:0] OP_POSITION  = 8'hFD;
    localparam logic [7:0] OP_STOP      = 8'hFE;
    localparam logic [7:0] SUB_STOP     = 8'h98;
    localparam logic [7:0] OP_CALIBRATE = 8'h06;
    localparam logic [7:0] SUB_CALIB    = 8'h45;

    localparam logic [1:0] REG_CHECK_MODE = 2'd0;

    // bytes[0] is sent first
    typedef struct packed {
        logic [FRAME_MAX-1:0][7:0] bytes;
        logic [3:0]                len;
    } t_frame;

    typedef struct packed {
        logic [7:0] data;
        logic       chk;
    } t_tok;

endpackage

// File: sv/scfe_if.sv
// Handshake channels: command items in, frame byte items out.
interface scfe_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  motor_address;
    logic [7:0]  direction;
    logic [15:0] speed;
    logic [7:0]  acceleration;
    logic [31:0] pulse_count;
    logic [7:0]  position_mode;
    logic [7:0]  en_byte;
    logic [7:0]  sync_byte;

    modport source(output valid, kind, motor_address, direction, speed, acceleration,
                   pulse_count, position_mode, en_byte, sync_byte,
                   input ready);
    modport sink(input valid, kind, motor_address, direction, speed, acceleration,
                 pulse_count, position_mode, en_byte, sync_byte,
                 output ready);
endinterface

interface scfe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source(output valid, frame_byte, last_byte, input ready);
    modport sink(input valid, frame_byte, last_byte, output ready);
endinterface

// File: sv/scfe_frame_build.sv
// Stage 1: assembles a command's frame bytes and length into a register.
module scfe_frame_build import scfe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scfe_cmd_if.sink    i_cmd,
    input  logic        i_take,
    output logic        o_vld,
    output t_frame      o_frm
);
    logic   r_vld, n_vld;
    t_frame r_frm, n_frm;
    logic   w_known;

    assign i_cmd.ready = !r_vld || i_take;
    assign o_vld = r_vld;
    assign o_frm = r_frm;

    always_comb begin
        n_frm.bytes    = '0;
        n_frm.len      = 4'd0;
        n_frm.bytes[0] = i_cmd.motor_address;
        w_known        = 1'b1;
        case (i_cmd.kind)
            KIND_ENABLE: begin
                n_frm.bytes[1] = OP_ENABLE;
                n_frm.bytes[2] = SUB_ENABLE;
                n_frm.bytes[3] = i_cmd.en_byte;
                n_frm.bytes[4] = i_cmd.sync_byte;
                n_frm.len      = 4'd5;
            end
            KIND_VELOCITY: begin
                n_frm.bytes[1] = OP_VELOCITY;
                n_frm.bytes[2] = i_cmd.direction;
                n_frm.bytes[3] = i_cmd.speed[15:8];
                n_frm.bytes[4] = i_cmd.speed[7:0];
                n_frm.bytes[5] = i_cmd.acceleration;
                n_frm.bytes[6] = i_cmd.sync_byte;
                n_frm.len      = 4'd7;
            end
            KIND_POSITION: begin
                n_frm.bytes[1]  = OP_POSITION;
                n_frm.bytes[2]  = i_cmd.direction;
                n_frm.bytes[3]  = i_cmd.speed[15:8];
                n_frm.bytes[4]  = i_cmd.speed[7:0];
                n_frm.bytes[5]  = i_cmd.acceleration;
                n_frm.bytes[6]  = i_cmd.pulse_count[31:24];
                n_frm.bytes[7]  = i_cmd.pulse_count[23:16];
                n_frm.bytes[8]  = i_cmd.pulse_count[15:8];
                n_frm.bytes[9]  = i_cmd.pulse_count[7:0];
                n_frm.bytes[10] = i_cmd.position_mode;
                n_frm.bytes[11] = i_cmd.sync_byte;
                n_frm.len       = 4'd12;
            end
            KIND_STOP: begin
                n_frm.bytes[1] = OP_STOP;
                n_frm.bytes[2] = SUB_STOP;
                n_frm.bytes[3] = i_cmd.sync_byte;
                n_frm.len      = 4'd4;
            end
            KIND_CALIBRATE: begin
                n_frm.bytes[1] = OP_CALIBRATE;
                n_frm.bytes[2] = SUB_CALIB;
                n_frm.len      = 4'd3;
            end
            default: begin
                w_known = 1'b0;  // unused kind: item is dropped
            end
        endcase
    end

    always_comb begin
        n_vld = r_vld && !i_take;
        if (i_cmd.valid && i_cmd.ready) begin
            n_vld = w_known;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_frm <= n_frm;
        end
    end
endmodule

// File: sv/scfe_serializer.sv
// Stage 2: shifts a frame out one byte per cycle while the output stage takes it, then a check token.
module scfe_serializer import scfe_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_vld,
    input  t_frame i_frm,
    output logic   o_take,
    output logic   o_tok_vld,
    output t_tok   o_tok,
    input  logic   i_tok_rdy
);
    logic                      r_busy, n_busy;
    logic [FRAME_MAX-1:0][7:0] r_bytes, n_bytes;
    logic [3:0]                r_rem, n_rem;
    logic                      w_fire, w_done;

    assign w_fire    = r_busy && i_tok_rdy;
    assign w_done    = w_fire && (r_rem == 4'd0);
    assign o_take    = i_vld && (!r_busy || w_done);
    assign o_tok_vld = r_busy;
    assign o_tok     = '{data: r_bytes[0], chk: (r_rem == 4'd0)};

    always_comb begin
        n_busy  = r_busy;
        n_bytes = r_bytes;
        n_rem   = r_rem;
        if (w_fire) begin
            n_bytes = r_bytes >> 8;
            n_rem   = r_rem - 4'd1;
            if (w_done) begin
                n_busy = 1'b0;
            end
        end
        if (o_take) begin
            n_busy  = 1'b1;
            n_bytes = i_frm.bytes;
            n_rem   = i_frm.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        r_rem   <= n_rem;
    end
endmodule

// File: sv/scfe_check_out.sv
// Stage 3: running XOR and CRC-8, check byte selection and output register.
module scfe_check_out import scfe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_mode,
    input  logic        i_tok_vld,
    input  t_tok        i_tok,
    output logic        o_tok_rdy,
    scfe_byte_if.source o_frame
);
    logic       r_ovld, n_ovld;
    logic [7:0] r_obyte, n_obyte;
    logic       r_olast, n_olast;
    logic [7:0] r_xor, n_xor;
    logic [7:0] r_crc, n_crc;
    logic [7:0] w_chk;
    logic       w_take;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    assign o_tok_rdy          = !r_ovld || o_frame.ready;
    assign w_take             = i_tok_vld && o_tok_rdy;
    assign o_frame.valid      = r_ovld;
    assign o_frame.frame_byte = r_obyte;
    assign o_frame.last_byte  = r_olast;

    always_comb begin
        case (i_mode)
            MODE_XOR: w_chk = r_xor;
            MODE_CRC: w_chk = r_crc;
            default:  w_chk = CHECK_CONST;
        endcase
    end

    always_comb begin
        n_ovld  = r_ovld && !o_frame.ready;
        n_obyte = r_obyte;
        n_olast = r_olast;
        n_xor   = r_xor;
        n_crc   = r_crc;
        if (w_take) begin
            n_ovld = 1'b1;
            if (i_tok.chk) begin
                n_obyte = w_chk;
                n_olast = 1'b1;
                n_xor   = 8'h00;
                n_crc   = 8'h00;
            end else begin
                n_obyte = i_tok.data;
                n_olast = 1'b0;
                n_xor   = r_xor ^ i_tok.data;
                n_crc   = crc8_step(r_crc, i_tok.data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_xor  <= 8'h00;
            r_crc  <= 8'h00;
        end else begin
            r_ovld <= n_ovld;
            r_xor  <= n_xor;
            r_crc  <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_obyte <= n_obyte;
        r_olast <= n_olast;
    end
endmodule

// File: sv/stepper_command_frame_encoder.sv
// Top level of the stepper command frame encoder: stages and register port.
// Usage:
//   i_cmd takes one motor command item per valid/ready handshake. The block
//   emits the command's frame on o_frame, one byte item per handshake, in
//   send order, with last_byte set on the trailing check byte.
//   Frames carry 3 to 12 frame bytes plus the check byte, 4 to 13 items.
//   check_mode (APB, byte address 0): 0 or 3 constant 0x6B, 1 XOR of the
//   frame bytes, 2 CRC-8 poly 0x07, init 0. Write it only while idle.
//   A command of an unused kind is accepted and emits nothing.
// Timing:
//   Three register stages: frame build, byte shifter, check/output register.
//   A command passes the frame register, then the shifter, then the output
//   register. The shifter sends one byte per cycle while the output stage
//   can take it; the next command is taken while the current frame drains,
//   and frames follow one another with no gap.
// Reset: synchronous, active low; clears the stages and sets check_mode to 0.
// Stall: when o_frame.ready is low every stage holds; bytes are never lost
//   or repeated, and i_cmd.ready drops once the stages are full.
module stepper_command_frame_encoder import scfe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scfe_cmd_if.sink    i_cmd,
    scfe_byte_if.source o_frame,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [1:0] r_mode;
    logic       w_frm_vld, w_frm_take;
    t_frame     w_frm;
    logic       w_tok_vld, w_tok_rdy;
    t_tok       w_tok;
    logic       w_sel0;

    assign pready = 1'b1;
    assign w_sel0 = ({1'b0, paddr[2]} == REG_CHECK_MODE);
    assign prdata = w_sel0 ? {30'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CONST;
        end else if (psel && penable && pwrite && pready && w_sel0) begin
            r_mode <= pwdata[1:0];
        end
    end

    scfe_frame_build u_build (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_take  (w_frm_take),
        .o_vld   (w_frm_vld),
        .o_frm   (w_frm)
    );

    scfe_serializer u_ser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (w_frm_vld),
        .i_frm     (w_frm),
        .o_take    (w_frm_take),
        .o_tok_vld (w_tok_vld),
        .o_tok     (w_tok),
        .i_tok_rdy (w_tok_rdy)
    );

    scfe_check_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (r_mode),
        .i_tok_vld (w_tok_vld),
        .i_tok     (w_tok),
        .o_tok_rdy (w_tok_rdy),
        .o_frame   (o_frame)
    );
endmodule

// File: tb/tb.sv
// Self-checking testbench of the stepper command frame encoder: directed table, then random items.
module tb;
    import scfe_pkg::*;

    localparam logic [2:0] KIND_RSVD5  = 3'd5;
    localparam logic [2:0] KIND_RSVD6  = 3'd6;
    localparam logic [2:0] KIND_RSVD7  = 3'd7;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] REG_SPARE   = 2'd1;
    localparam logic [2:0] ADDR_CHECK_MODE = 3'(4 * REG_CHECK_MODE);
    localparam logic [2:0] ADDR_SPARE      = 3'(4 * REG_SPARE);
    localparam int DRAIN_CYCLES = 8;
    localparam int END_CYCLES   = 20;
    localparam int ITEMS_PER_CHUNK = 37;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  addr;
        logic [7:0]  dir;
        logic [15:0] spd;
        logic [7:0]  acc;
        logic [31:0] pulses;
        logic [7:0]  pmode;
        logic [7:0]  en;
        logic [7:0]  sync;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       known;
        logic [7:0] chk;
        t_cmd       cmd;
    } t_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    scfe_cmd_if  cmd_ch();
    scfe_byte_if frm_ch();

    t_tok        frame_q[$];
    logic [1:0]  cur_mode = MODE_CONST;
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    int unsigned err_cnt = 0;

    stepper_command_frame_encoder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_frame (frm_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    t_row directed_rows [0:23] = '{
        '{MODE_CONST, 1'b1, CHECK_CONST, '{KIND_ENABLE, 8'h00, 8'h00, 16'h0000, 8'h00,
            32'h0000_0000, 8'h00, 8'h00, 8'h00}},
        '{MODE_CONST, 1'b1, CHECK_CONST, '{KIND_ENABLE, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
            32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF}},
        '{MODE_CONST, 1'b1, CHECK_CONST, '{KIND_VELOCITY, 8'h00, 8'h00, 16'h0000, 8'h00,
            32'h0000_0000, 8'h00, 8'h00, 8'h00}},
        '{MODE_CONST, 1'b1, CHECK_CONST, '{KIND_VELOCITY, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
            32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF}},
        '{MODE_CONST, 1'b1, CHECK_CONST, '{KIND_POSITION, 8'h01, 8'h01, 16'h1234, 8'h56,
            32'h89AB_CDEF, 8'h01, 8'h00, 8'h00}},
        '{MODE_CONST, 1'b1, CHECK_CONST, '{KIND_POSITION, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
            32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF}},
        '{MODE_CONST, 1'b1, CHECK_CONST, '{KIND_STOP, 8'h00, 8'h00, 16'h0000, 8'h00,
            32'h0000_0000, 8'h00, 8'h00, 8'h00}},
        '{MODE_CONST, 1'b1, CHECK_CONST, '{KIND_CALIBRATE, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
            32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF}},
        '{MODE_CONST, 1'b0, 8'h00, '{KIND_RSVD5, 8'h12, 8'h34, 16'h5678, 8'h9A,
            32'hDEAD_BEEF, 8'h01, 8'h01, 8'h01}},
        '{MODE_CONST, 1'b0, 8'h00, '{KIND_RSVD6, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
            32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF}},
        '{MODE_CONST, 1'b0, 8'h00, '{KIND_RSVD7, 8'h00, 8'h00, 16'h0000, 8'h00,
            32'h0000_0000, 8'h00, 8'h00, 8'h00}},
        '{MODE_XOR, 1'b1, 8'h43, '{KIND_CALIBRATE, 8'h00, 8'h00, 16'h0000, 8'h00,
            32'h0000_0000, 8'h00, 8'h00, 8'h00}},
        '{MODE_XOR, 1'b1, 8'h66, '{KIND_STOP, 8'h00, 8'hFF, 16'hFFFF, 8'hFF,
            32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'h00}},
        '{MODE_XOR, 1'b1, 8'hFD, '{KIND_POSITION, 8'h00, 8'h00, 16'h0000, 8'h00,
            32'h0000_0000, 8'h00, 8'h00, 8'h00}},
        '{MODE_XOR, 1'b0, 8'h00, '{KIND_ENABLE, 8'hA5, 8'h00, 16'h0000, 8'h00,
            32'h0000_0000, 8'h00, 8'h01, 8'h01}},
        '{MODE_XOR, 1'b0, 8'h00, '{KIND_VELOCITY, 8'h3C, 8'h01, 16'h05DC, 8'h0A,
            32'h0000_0000, 8'h00, 8'h00, 8'h01}},
        '{MODE_CRC, 1'b0, 8'h00, '{KIND_CALIBRATE, 8'h00, 8'h00, 16'h0000, 8'h00,
            32'h0000_0000, 8'h00, 8'h00, 8'h00}},
        '{MODE_CRC, 1'b0, 8'h00, '{KIND_ENABLE, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
            32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF}},
        '{MODE_CRC, 1'b0, 8'h00, '{KIND_POSITION, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
            32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF}},
        '{MODE_CRC, 1'b0, 8'h00, '{KIND_VELOCITY, 8'h00, 8'h00, 16'h0000, 8'h00,
            32'h0000_0000, 8'h00, 8'h00, 8'h00}},
        '{MODE_CRC, 1'b0, 8'h00, '{KIND_STOP, 8'h80, 8'h00, 16'h0000, 8'h00,
            32'h0000_0000, 8'h00, 8'h00, 8'h80}},
        '{MODE_CRC, 1'b0, 8'h00, '{KIND_RSVD7, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
            32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF}},
        '{MODE_UNUSED, 1'b1, CHECK_CONST, '{KIND_CALIBRATE, 8'h00, 8'h00, 16'h0000, 8'h00,
            32'h0000_0000, 8'h00, 8'h00, 8'h00}},
        '{MODE_UNUSED, 1'b1, CHECK_CONST, '{KIND_POSITION, 8'h5A, 8'hA5, 16'h8001, 8'h7F,
            32'h8000_0001, 8'h01, 8'h00, 8'h01}}
    };

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch: %s got %h want %h", what, got, want);
        err_cnt++;
    endtask

    // bytes of one command frame, check byte last
    function automatic void predict_frame(t_cmd c, logic [1:0] mode);
        logic [7:0] fb[$];
        logic [7:0] chk;
        t_tok       tok;
        fb.push_back(c.addr);
        case (c.kind)
            KIND_ENABLE: begin
                fb.push_back(OP_ENABLE); fb.push_back(SUB_ENABLE);
                fb.push_back(c.en); fb.push_back(c.sync);
            end
            KIND_VELOCITY: begin
                fb.push_back(OP_VELOCITY); fb.push_back(c.dir);
                fb.push_back(c.spd[15:8]); fb.push_back(c.spd[7:0]);
                fb.push_back(c.acc); fb.push_back(c.sync);
            end
            KIND_POSITION: begin
                fb.push_back(OP_POSITION); fb.push_back(c.dir);
                fb.push_back(c.spd[15:8]); fb.push_back(c.spd[7:0]);
                fb.push_back(c.acc);
                fb.push_back(c.pulses[31:24]); fb.push_back(c.pulses[23:16]);
                fb.push_back(c.pulses[15:8]); fb.push_back(c.pulses[7:0]);
                fb.push_back(c.pmode); fb.push_back(c.sync);
            end
            KIND_STOP: begin
                fb.push_back(OP_STOP); fb.push_back(SUB_STOP); fb.push_back(c.sync);
            end
            KIND_CALIBRATE: begin
                fb.push_back(OP_CALIBRATE); fb.push_back(SUB_CALIB);
            end
            default: return;
        endcase
        chk = 8'h00;
        if (mode == MODE_XOR) begin
            foreach (fb[i]) chk = chk ^ fb[i];
        end else if (mode == MODE_CRC) begin
            foreach (fb[i]) begin
                chk = chk ^ fb[i];
                for (int b = 0; b < 8; b++) begin
                    chk = chk[7] ? ((chk << 1) ^ CRC_POLY) : (chk << 1);
                end
            end
        end else begin
            chk = CHECK_CONST;
        end
        foreach (fb[i]) begin
            tok.data = fb[i];
            tok.chk  = 1'b0;
            frame_q.push_back(tok);
        end
        tok.data = chk;
        tok.chk  = 1'b1;
        frame_q.push_back(tok);
    endfunction

    function automatic logic [31:0] pick_bits(int unsigned w);
        logic [31:0] m;
        m = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
        case ($urandom_range(7))
            0: return 32'd0;
            1: return m;
            default: return $urandom & m;
        endcase
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        if ($urandom_range(9) == 0) c.kind = 3'($urandom_range(7, 5));
        else c.kind = 3'($urandom_range(4));
        c.addr   = 8'(pick_bits(8));
        c.dir    = 8'(pick_bits(8));
        c.spd    = 16'(pick_bits(16));
        c.acc    = 8'(pick_bits(8));
        c.pulses = pick_bits(32);
        c.pmode  = 8'(pick_bits(8));
        c.en     = 8'(pick_bits(8));
        c.sync   = 8'(pick_bits(8));
        return c;
    endfunction

    task automatic send_cmd(t_cmd c, logic known, logic [7:0] chk);
        t_tok tok;
        while ($urandom_range(99) < snd_idle_pct) begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
        end
        @(negedge clk);
        cmd_ch.valid         <= 1'b1;
        cmd_ch.kind          <= c.kind;
        cmd_ch.motor_address <= c.addr;
        cmd_ch.direction     <= c.dir;
        cmd_ch.speed         <= c.spd;
        cmd_ch.acceleration  <= c.acc;
        cmd_ch.pulse_count   <= c.pulses;
        cmd_ch.position_mode <= c.pmode;
        cmd_ch.en_byte       <= c.en;
        cmd_ch.sync_byte     <= c.sync;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        predict_frame(c, cur_mode);
        if (known) begin
            tok = frame_q.pop_back();
            tok.data = chk;
            frame_q.push_back(tok);
        end
    endtask

    task automatic wait_frames_done();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (frame_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ADDR_CHECK_MODE) cur_mode = data[1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_mode_readback();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_CHECK_MODE;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[1:0] !== cur_mode)
            report_mismatch("check_mode read", prdata, 32'(cur_mode));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_check_mode(logic [1:0] mode);
        logic [31:0] wdata;
        wdata = $urandom;
        wdata[1:0] = mode;
        apb_write(ADDR_CHECK_MODE, wdata);
        check_mode_readback();
    endtask

    always @(negedge clk) begin
        frm_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge clk) begin
        t_tok want;
        if (rst_n && frm_ch.valid && frm_ch.ready) begin
            if (frame_q.size() == 0) begin
                report_mismatch("unexpected frame byte", 32'(frm_ch.frame_byte), 32'd0);
            end else begin
                want = frame_q.pop_front();
                if (frm_ch.frame_byte !== want.data)
                    report_mismatch("frame_byte", 32'(frm_ch.frame_byte), 32'(want.data));
                if (frm_ch.last_byte !== want.chk)
                    report_mismatch("last_byte", 32'(frm_ch.last_byte), 32'(want.chk));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        cmd_ch.valid         = 1'b0;
        cmd_ch.kind          = '0;
        cmd_ch.motor_address = '0;
        cmd_ch.direction     = '0;
        cmd_ch.speed         = '0;
        cmd_ch.acceleration  = '0;
        cmd_ch.pulse_count   = '0;
        cmd_ch.position_mode = '0;
        cmd_ch.en_byte       = '0;
        cmd_ch.sync_byte     = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        cur_mode = MODE_CONST;
        check_mode_readback();

        snd_idle_pct = 26;
        rcv_idle_pct = 54;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].mode != cur_mode) begin
                wait_frames_done();
                set_check_mode(directed_rows[i].mode);
            end
            send_cmd(directed_rows[i].cmd, directed_rows[i].known, directed_rows[i].chk);
        end

        // write beyond the register list must leave check_mode alone
        wait_frames_done();
        apb_write(ADDR_SPARE, $urandom);
        check_mode_readback();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin snd_idle_pct = 26; rcv_idle_pct = 54; end
                1: begin snd_idle_pct = 54; rcv_idle_pct = 26; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            for (int chunk = 0; chunk < 4; chunk++) begin
                wait_frames_done();
                if ($urandom_range(3) == 0) apb_write(ADDR_SPARE, $urandom);
                set_check_mode(2'(chunk + phase));
                for (int n = 0; n < ITEMS_PER_CHUNK; n++) begin
                    if ($urandom_range(39) == 0) wait_frames_done();
                    send_cmd(random_cmd(), 1'b0, 8'h00);
                end
            end
        end

        wait_frames_done();
        repeat (END_CYCLES) @(posedge clk);
        if (frame_q.size() != 0)
            report_mismatch("frame bytes never sent", 32'(frame_q.size()), 32'd0);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
